[rtl/core/vmcc_pkg.sv]
package vmcc_pkg;

  localparam int MAX_ELEMENTS = 256;

  localparam int XLEN      = 64;
  localparam int ADD_W     = XLEN + 2;
  localparam int IDX_W     = 8;
  localparam int OP_W      = 4;
  localparam int EWC_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam int CMP_W     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_EQ     = 4'd0,
    OP_NE     = 4'd1,
    OP_SLT    = 4'd2,
    OP_SLE    = 4'd3,
    OP_SGT    = 4'd4,
    OP_SGE    = 4'd5,
    OP_ULT    = 4'd6,
    OP_ULE    = 4'd7,
    OP_UGT    = 4'd8,
    OP_UGE    = 4'd9,
    OP_CARRY  = 4'd10,
    OP_BORROW = 4'd11
  } op_t;

  typedef enum logic [EWC_W-1:0] {
    EW_8  = 2'd0,
    EW_16 = 2'd1,
    EW_32 = 2'd2,
    EW_64 = 2'd3
  } ewc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEMENT_WIDTH = 1'd0,
    REG_FIRST_ELEMENT = 1'd1
  } cfg_reg_t;

  // adder operands, already inverted for subtract
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADD_W-1:0]  x;
    logic [ADD_W-1:0]  y;
    logic              c;
    logic              wr_en;
    logic              old_bit;
    logic [IDX_W-1:0]  idx;
    logic [EWC_W-1:0]  ewc;
  } prep_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              lt;
    logic              eq;
    logic              cbit;
    logic              wr_en;
    logic              old_bit;
    logic [IDX_W-1:0]  idx;
  } flags_t;

  function automatic logic [XLEN-1:0] extend_elem(input logic [XLEN-1:0] v,
                                                  input logic [EWC_W-1:0] ewc,
                                                  input logic sgn);
    logic [XLEN-1:0] r;
    begin
      case (ewc)
        EW_8:    r = {{(XLEN-8){sgn & v[7]}}, v[7:0]};
        EW_16:   r = {{(XLEN-16){sgn & v[15]}}, v[15:0]};
        EW_32:   r = {{(XLEN-32){sgn & v[31]}}, v[31:0]};
        default: r = v;
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/core/vmcc_prep.sv]
module vmcc_prep
  import vmcc_pkg::*;
(
  input  logic [OP_W-1:0]   operation,
  input  logic [XLEN-1:0]   lhs_element,
  input  logic [XLEN-1:0]   rhs_value,
  input  logic              rhs_is_scalar,
  input  logic              mask_source_bit,
  input  logic              masked,
  input  logic              old_mask_bit,
  input  logic [IDX_W-1:0]  element_index,
  input  logic [EWC_W-1:0]  ewc,
  input  logic [IDX_W-1:0]  first_element,
  output prep_t             prep
);

  logic            is_cmp;
  logic            is_sgn;
  logic            in_range;
  logic            op_ok;
  logic            cin;
  logic            sub;
  logic [XLEN-1:0] a;
  logic [XLEN-1:0] b;
  logic [ADD_W-1:0] y;

  always_comb begin
    is_cmp   = operation inside {[OP_EQ:OP_UGE]};
    op_ok    = operation inside {[OP_EQ:OP_BORROW]};
    is_sgn   = is_cmp && (operation inside {[OP_EQ:OP_SGE]});
    in_range = (element_index >= first_element) &&
               (CMP_W'(element_index) < CMP_W'(MAX_ELEMENTS));
    cin      = masked ? 1'b0 : mask_source_bit;
    sub      = (operation != OP_CARRY);

    a = extend_elem(lhs_element, ewc, is_sgn);
    // scalar right operand is full width for compares only
    b = (rhs_is_scalar && is_cmp) ? rhs_value : extend_elem(rhs_value, ewc, is_sgn);
    y = {{2{is_sgn & b[XLEN-1]}}, b};

    prep.op      = operation;
    prep.x       = {{2{is_sgn & a[XLEN-1]}}, a};
    prep.y       = sub ? ~y : y;
    // x - y - bin == x + ~y + ~bin
    if (is_cmp) begin
      prep.c = 1'b1;
    end else if (sub) begin
      prep.c = ~cin;
    end else begin
      prep.c = cin;
    end
    prep.wr_en   = in_range && op_ok && (!is_cmp || !masked || mask_source_bit);
    prep.old_bit = old_mask_bit;
    prep.idx     = element_index;
    prep.ewc     = ewc;
  end

endmodule

[rtl/core/vector_mask_compare_carry_unit_core.sv]
// throughput: one word per cycle while out_stall is low; three register stages
// (operand prep, 66-bit adder, result select) advance independently under stall
// reset: rst_n is synchronous and active low; it empties the pipeline and sets
// element width to 8 bits and first element to 0
module vector_mask_compare_carry_unit_core
  import vmcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [XLEN-1:0]       in_lhs_element,
  input  logic [XLEN-1:0]       in_rhs_value,
  input  logic                  in_rhs_is_scalar,
  input  logic                  in_mask_source_bit,
  input  logic                  in_masked,
  input  logic                  in_old_mask_bit,
  input  logic [IDX_W-1:0]      in_element_index,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      out_element_number,
  output logic                  out_new_mask_bit,
  output logic                  out_was_written,

  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  logic [EWC_W-1:0] ewc_r;
  logic [IDX_W-1:0] first_r;

  prep_t  s1_nxt, s1_r;
  flags_t s2_nxt, s2_r;
  logic   v1_r, v2_r, v3_r;
  logic   adv1, adv2, adv3;

  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_bit_r, out_bit_nxt;
  logic              out_wr_r,  out_wr_nxt;
  logic [ADD_W-1:0]  sum;
  logic              r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ewc_r   <= EW_8;
      first_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ELEMENT_WIDTH: ewc_r   <= cfg_data[EWC_W-1:0];
        REG_FIRST_ELEMENT: first_r <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  vmcc_prep u_prep (
    .operation       (in_operation),
    .lhs_element     (in_lhs_element),
    .rhs_value       (in_rhs_value),
    .rhs_is_scalar   (in_rhs_is_scalar),
    .mask_source_bit (in_mask_source_bit),
    .masked          (in_masked),
    .old_mask_bit    (in_old_mask_bit),
    .element_index   (in_element_index),
    .ewc             (ewc_r),
    .first_element   (first_r),
    .prep            (s1_nxt)
  );

  // stage 2: shared adder for compare, carry and borrow
  always_comb begin
    sum = s1_r.x + s1_r.y + ADD_W'(s1_r.c);
    s2_nxt.op      = s1_r.op;
    s2_nxt.lt      = sum[ADD_W-1];
    s2_nxt.eq      = (sum == '0);
    case (s1_r.ewc)
      EW_8:    s2_nxt.cbit = sum[8];
      EW_16:   s2_nxt.cbit = sum[16];
      EW_32:   s2_nxt.cbit = sum[32];
      default: s2_nxt.cbit = sum[64];
    endcase
    s2_nxt.wr_en   = s1_r.wr_en;
    s2_nxt.old_bit = s1_r.old_bit;
    s2_nxt.idx     = s1_r.idx;
  end

  // stage 3: pick the result bit
  always_comb begin
    case (s2_r.op)
      OP_EQ:                    r = s2_r.eq;
      OP_NE:                    r = !s2_r.eq;
      OP_SLT, OP_ULT:           r = s2_r.lt;
      OP_SLE, OP_ULE:           r = s2_r.lt || s2_r.eq;
      OP_SGT, OP_UGT:           r = !s2_r.lt && !s2_r.eq;
      OP_SGE, OP_UGE:           r = !s2_r.lt;
      // borrow out shows as the top bit of the negative difference
      OP_CARRY, OP_BORROW:      r = s2_r.cbit;
      default:                  r = s2_r.old_bit;
    endcase
    out_idx_nxt = s2_r.idx;
    out_bit_nxt = s2_r.wr_en ? r : s2_r.old_bit;
    out_wr_nxt  = s2_r.wr_en;
  end

  always_ff @(posedge clk) begin
    if (adv1) s1_r <= s1_nxt;
    if (adv2) s2_r <= s2_nxt;
    if (adv3) begin
      out_idx_r <= out_idx_nxt;
      out_bit_r <= out_bit_nxt;
      out_wr_r  <= out_wr_nxt;
    end
  end

  assign out_valid          = v3_r;
  assign out_element_number = out_idx_r;
  assign out_new_mask_bit   = out_bit_r;
  assign out_was_written    = out_wr_r;

endmodule
